// File: rtl/core/tma_pkg.sv
// Shared constants, ALU op codes and control struct for the trimmed-mean oversampler.
`default_nettype none

package tma_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int MAX_SAMPLES_DEF  = 16;

	localparam int WORD_W      = 16;
	localparam int SAMPLE_W    = 12;
	localparam int TAG_LSB     = 13;
	localparam int TAG_W       = 3;
	localparam int ACTIVE_W    = 3;
	localparam int COUNT_W     = 5;
	localparam int COUNT_REGS  = 4;
	localparam int CREG_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 5;
	localparam int RESULT_CH_W = 2;
	localparam int AVG_W       = 20;
	localparam int FRAC_BITS   = 8;
	localparam int SUM_W       = SAMPLE_W + COUNT_W;
	localparam int ALU_W       = SUM_W + 1;
	localparam int DVD_W       = SUM_W + FRAC_BITS;
	localparam int STEP_W      = 5;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_CHAN0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_CHAN3     = 3'd4;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;
	localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd4;
	localparam logic [COUNT_W-1:0]  COUNT_MIN    = 5'd3;
	localparam logic [COUNT_W-1:0]  TRIM_DROP    = 5'd2;

	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_ACC      = 3'd1,
		OP_SUB_HI   = 3'd2,
		OP_SUB_LO   = 3'd3,
		OP_DIV_LOAD = 3'd4,
		OP_DIV_STEP = 3'd5
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               first;
		logic [COUNT_W-1:0] divisor;
	} dp_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/tma_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tma_ram #(
	parameter int WIDTH = tma_pkg::SAMPLE_W,
	parameter int DEPTH = tma_pkg::NUM_CHANNELS_DEF * tma_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/tma_datapath.sv
// Shared add/subtract unit with sum, max/min and restoring-divide registers.
`default_nettype none

module tma_datapath (
	input  wire logic                          clk,
	input  wire tma_pkg::dp_ctrl_t             ctrl,
	input  wire logic [tma_pkg::SAMPLE_W-1:0]  rd_data,
	output logic      [tma_pkg::AVG_W-1:0]     quotient
);

	localparam int SUM_W = tma_pkg::SUM_W;
	localparam int ALU_W = tma_pkg::ALU_W;
	localparam int DVD_W = tma_pkg::DVD_W;
	localparam int CNT_W = tma_pkg::COUNT_W;

	logic [SUM_W-1:0]             sum_q;
	logic [tma_pkg::SAMPLE_W-1:0] hi_q;
	logic [tma_pkg::SAMPLE_W-1:0] lo_q;
	logic [CNT_W-1:0]             rem_q;
	logic [DVD_W-1:0]             quo_q;

	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic             alu_sub;
	logic [ALU_W-1:0] alu_y;
	logic [CNT_W:0]   shift_in;

	assign shift_in = {rem_q, quo_q[DVD_W-1]};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (ctrl.op)
			tma_pkg::OP_ACC: begin
				alu_a = ctrl.first ? '0 : {1'b0, sum_q};
				alu_b = ALU_W'(rd_data);
			end
			tma_pkg::OP_SUB_HI: begin
				alu_a   = {1'b0, sum_q};
				alu_b   = ALU_W'(hi_q);
				alu_sub = 1'b1;
			end
			tma_pkg::OP_SUB_LO: begin
				alu_a   = {1'b0, sum_q};
				alu_b   = ALU_W'(lo_q);
				alu_sub = 1'b1;
			end
			tma_pkg::OP_DIV_STEP: begin
				alu_a   = ALU_W'(shift_in);
				alu_b   = ALU_W'(ctrl.divisor);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
		alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			tma_pkg::OP_ACC: begin
				sum_q <= alu_y[SUM_W-1:0];
				if (ctrl.first) begin
					hi_q <= rd_data;
					lo_q <= rd_data;
				end else begin
					if (rd_data > hi_q) hi_q <= rd_data;
					if (rd_data < lo_q) lo_q <= rd_data;
				end
			end
			tma_pkg::OP_SUB_HI, tma_pkg::OP_SUB_LO: begin
				sum_q <= alu_y[SUM_W-1:0];
			end
			tma_pkg::OP_DIV_LOAD: begin
				quo_q <= {sum_q, {tma_pkg::FRAC_BITS{1'b0}}};
				rem_q <= '0;
			end
			tma_pkg::OP_DIV_STEP: begin
				// borrow set: keep shifted remainder, quotient bit 0
				if (alu_y[ALU_W-1]) begin
					rem_q <= shift_in[CNT_W-1:0];
				end else begin
					rem_q <= alu_y[CNT_W-1:0];
				end
				quo_q <= {quo_q[DVD_W-2:0], ~alu_y[ALU_W-1]};
			end
			default: begin
			end
		endcase
	end

	assign quotient = quo_q[tma_pkg::AVG_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/adc_trimmed_mean_oversampler_top.sv
// Trimmed-mean oversampler top level: config registers, sequencer, sample RAM.
// A dropped word or one that only fills a buffer slot is taken in idle; in_ready stays high.
// A word that completes a buffer of n samples starts a run that ends in out_valid: a walk
// over the n samples, 2 trim subtracts, a load, 25 divide steps, the output register.
// in_ready returns with out_valid, so no new word goes in during the run; a result still
// held by the sink delays this. Reset clears the RAM.
`default_nettype none

module adc_trimmed_mean_oversampler_top #(
	parameter int NUM_CHANNELS = tma_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_SAMPLES  = tma_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// config write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tma_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tma_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input word channel
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [tma_pkg::WORD_W-1:0]       raw_word,
	// result word channel
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [tma_pkg::RESULT_CH_W-1:0]  result_channel,
	output logic      [tma_pkg::AVG_W-1:0]        trimmed_average
);

	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int IDX_W  = $clog2(MAX_SAMPLES);
	localparam int ADDR_W = CH_W + IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int CMP_W  = (IDX_W + 1 > tma_pkg::COUNT_W) ? IDX_W + 1 : tma_pkg::COUNT_W;
	localparam int LIM_W  = tma_pkg::TAG_W + 1;
	localparam int CNT_W  = tma_pkg::COUNT_W;
	localparam int STEP_W = tma_pkg::STEP_W;

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_WALK     = 8'b0000_0100,
		ST_SUB_HI   = 8'b0000_1000,
		ST_SUB_LO   = 8'b0001_0000,
		ST_DIV_LOAD = 8'b0010_0000,
		ST_DIV      = 8'b0100_0000,
		ST_FINISH   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// ------------------------------------------------------------------
	// Config registers. Always ready; a write lands at once, so it belongs
	// between words.
	// ------------------------------------------------------------------
	logic [tma_pkg::ACTIVE_W-1:0] active_q;
	logic [CNT_W-1:0]             count_q [tma_pkg::COUNT_REGS];
	logic [tma_pkg::CFG_IDX_W-1:0] cfg_off;
	logic [CNT_W-1:0]             cfg_count;

	assign cfg_ready = 1'b1;
	assign cfg_off   = cfg_index - tma_pkg::REG_COUNT_CHAN0;

	// counts saturate to 3..MAX_SAMPLES
	always_comb begin
		if (cfg_data < tma_pkg::COUNT_MIN) begin
			cfg_count = tma_pkg::COUNT_MIN;
		end else if (32'(cfg_data) > MAX_SAMPLES) begin
			cfg_count = CNT_W'(MAX_SAMPLES);
		end else begin
			cfg_count = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= tma_pkg::ACTIVE_RESET;
			for (int i = 0; i < tma_pkg::COUNT_REGS; i++) begin
				count_q[i] <= tma_pkg::COUNT_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tma_pkg::REG_ACTIVE_CHANNELS) begin
				active_q <= cfg_data[tma_pkg::ACTIVE_W-1:0];
			end else if (cfg_index >= tma_pkg::REG_COUNT_CHAN0 &&
			             cfg_index <= tma_pkg::REG_COUNT_CHAN3) begin
				count_q[cfg_off[tma_pkg::CREG_W-1:0]] <= cfg_count;
			end
			// indexes past the list are ignored
		end
	end

	// ------------------------------------------------------------------
	// Input word decode: tag, drop check, fill index advance.
	// ------------------------------------------------------------------
	logic [tma_pkg::TAG_W-1:0]    tag;
	logic [CH_W-1:0]              ch_sel;
	logic [LIM_W-1:0]             limit;
	logic                         drop;
	logic                         take;
	logic [CNT_W-1:0]             n_sel;
	logic [IDX_W-1:0]             fill_q [NUM_CHANNELS];
	logic [IDX_W-1:0]             fill_cur;
	logic [IDX_W:0]               fill_next;
	logic                         full;

	assign tag    = raw_word[tma_pkg::TAG_LSB +: tma_pkg::TAG_W];
	assign ch_sel = tag[CH_W-1:0];
	// active count above the channel count acts as the channel count
	assign limit  = ({1'b0, active_q} > LIM_W'(NUM_CHANNELS)) ? LIM_W'(NUM_CHANNELS)
	                                                          : {1'b0, active_q};
	assign drop      = ({1'b0, tag} >= limit);
	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready && !drop;
	// wide channel parameter: count register picked by low tag bits
	assign n_sel     = count_q[tag[tma_pkg::CREG_W-1:0]];
	assign fill_cur  = fill_q[ch_sel];
	assign fill_next = {1'b0, fill_cur} + 1'b1;
	// also catches a count lowered below the current fill point
	assign full      = (CMP_W'(fill_next) >= CMP_W'(n_sel));

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0]               clr_q;
	logic [STEP_W-1:0]               step_q;
	logic [CH_W-1:0]                 ch_q;
	logic [CNT_W-1:0]                n_q;
	logic [tma_pkg::RESULT_CH_W-1:0] rch_q;
	logic                            out_valid_q;
	logic [tma_pkg::RESULT_CH_W-1:0] result_channel_q;
	logic [tma_pkg::AVG_W-1:0]       trimmed_average_q;
	logic [tma_pkg::AVG_W-1:0]       quotient;
	logic                            out_load;

	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take) begin
						if (full) begin
							fill_q[ch_sel] <= '0;
							step_q         <= '0;
							state_q        <= ST_WALK;
						end else begin
							fill_q[ch_sel] <= fill_next[IDX_W-1:0];
						end
					end
				end
				ST_WALK: begin
					// read issued at step s, accumulated at step s+1
					if (step_q == STEP_W'(n_q)) begin
						step_q  <= '0;
						state_q <= ST_SUB_HI;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SUB_HI: state_q <= ST_SUB_LO;
				ST_SUB_LO: state_q <= ST_DIV_LOAD;
				ST_DIV_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(tma_pkg::DVD_W - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// wait here while the previous result is still held
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item context and output word
	always_ff @(posedge clk) begin
		if (take && full) begin
			ch_q  <= ch_sel;
			n_q   <= n_sel;
			rch_q <= tag[tma_pkg::RESULT_CH_W-1:0];
		end
		if (out_load) begin
			result_channel_q  <= rch_q;
			trimmed_average_q <= quotient;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_channel  = result_channel_q;
	assign trimmed_average = trimmed_average_q;

	// ------------------------------------------------------------------
	// Sample RAM: clear pass after reset, sample writes, walk reads.
	// ------------------------------------------------------------------
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [tma_pkg::SAMPLE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]            ram_raddr;
	logic [tma_pkg::SAMPLE_W-1:0] ram_rdata;
	logic [IDX_W+STEP_W-1:0]      step_ext;

	assign step_ext  = {{IDX_W{1'b0}}, step_q};
	assign ram_we    = (state_q == ST_CLEAR) || take;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : {ch_sel, fill_cur};
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : raw_word[tma_pkg::SAMPLE_W-1:0];
	assign ram_raddr = {ch_q, step_ext[IDX_W-1:0]};

	tma_ram #(
		.WIDTH (tma_pkg::SAMPLE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Datapath control
	// ------------------------------------------------------------------
	tma_pkg::dp_ctrl_t dp_ctrl;

	always_comb begin
		dp_ctrl.op      = tma_pkg::OP_NONE;
		dp_ctrl.first   = 1'b0;
		dp_ctrl.divisor = n_q - tma_pkg::TRIM_DROP;
		case (state_q)
			ST_WALK: begin
				if (step_q != '0) begin
					dp_ctrl.op    = tma_pkg::OP_ACC;
					dp_ctrl.first = (step_q == STEP_W'(1));
				end
			end
			ST_SUB_HI:   dp_ctrl.op = tma_pkg::OP_SUB_HI;
			ST_SUB_LO:   dp_ctrl.op = tma_pkg::OP_SUB_LO;
			ST_DIV_LOAD: dp_ctrl.op = tma_pkg::OP_DIV_LOAD;
			ST_DIV:      dp_ctrl.op = tma_pkg::OP_DIV_STEP;
			default: begin
			end
		endcase
	end

	tma_datapath u_dp (
		.clk      (clk),
		.ctrl     (dp_ctrl),
		.rd_data  (ram_rdata),
		.quotient (quotient)
	);

endmodule

`default_nettype wire
